// File: design/lidar_footprint_box_mask_defines.svh
//------------------------------------------------------------------------------
// Footprint box mask assertion macros
// Shared concurrent assertion forms used by the footprint box mask design.
//------------------------------------------------------------------------------
`ifndef LIDAR_FOOTPRINT_BOX_MASK_DEFINES_SVH
`define LIDAR_FOOTPRINT_BOX_MASK_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LFBM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("footprint box mask: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define LFBM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("footprint box mask: next-cycle check failed");

`endif

// File: design/lfbm_pkg.sv
//------------------------------------------------------------------------------
// Footprint box mask package
// Types, register codes and the constant sine table shared by the design.
//------------------------------------------------------------------------------
package lfbm_pkg;

   localparam int TRIG_TABLE_BITS = 10;
   localparam int PHASE_BITS      = 24;
   localparam int QUARTER_BITS    = TRIG_TABLE_BITS - 2;
   localparam int TABLE_QUARTER   = 1 << QUARTER_BITS;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int SKIP_W      = 8;

   localparam logic [PHASE_BITS-1:0] PHASE_HALF = {1'b1, {(PHASE_BITS-1){1'b0}}};

   typedef logic [PHASE_BITS-1:0]      phase_type;
   typedef logic [TRIG_TABLE_BITS-1:0] trig_index_type;
   typedef logic [14:0]                qval_type;
   typedef qval_type [TABLE_QUARTER-1:0] qtab_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HALF_WIDTH  = 3'd0,
      CSR_FRONT_LIMIT = 3'd1,
      CSR_BACK_LIMIT  = 3'd2,
      CSR_RANGE_MAX   = 3'd3,
      CSR_PHASE_STEP  = 3'd4,
      CSR_SKIP_SCANS  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [15:0] range_mm;
      logic [15:0] intensity;
      logic        scan_end;
   } req_type;

   typedef struct packed {
      logic [15:0] out_range_mm;
      logic [15:0] out_intensity;
      logic        out_scan_end;
      logic        masked;
   } rsp_type;

   typedef struct packed {
      logic [14:0]        half_width_mm;
      logic signed [15:0] front_limit_mm;
      logic signed [15:0] back_limit_mm;
      logic [15:0]        range_max_mm;
      logic [23:0]        phase_step;
   } cfg_type;

   // First-quadrant sine in Q15, from a truncated Taylor series in Q30.
   function automatic qval_type quarter_sine(input int unsigned k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      longint      sum;
      longint      q;
      x    = (HALF_PI_Q30 * 64'(k)) / TABLE_QUARTER;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int unsigned n = 1; n <= 8; n++) begin
         term = (term * x2) >> 30;
         term = term / 64'((2 * n) * (2 * n + 1));
         if ((n % 2) == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      q = (sum + 16384) >>> 15;
      if (q > 32767) begin
         q = 32767;
      end
      return qval_type'(q);
   endfunction

   function automatic qtab_type build_qtab();
      qtab_type t;
      for (int k = 0; k < TABLE_QUARTER; k++) begin
         t[k] = quarter_sine(k);
      end
      return t;
   endfunction

   localparam qtab_type QTAB = build_qtab();
   localparam qval_type QTOP = quarter_sine(TABLE_QUARTER);

endpackage

// File: design/lfbm_point_check.sv
//------------------------------------------------------------------------------
// Footprint box point check
// Looks up sine and cosine of the beam angle, projects the range sample to
// x and y and tests the point against the footprint box.
//------------------------------------------------------------------------------
module lfbm_point_check (
   input  lfbm_pkg::cfg_type        cfg,
   input  lfbm_pkg::trig_index_type trig_index,
   input  logic [15:0]              range_mm,
   output logic                     masked,
   output logic [15:0]              out_range_mm
);

   // Full-turn sine from the quarter table by symmetry.
   function automatic logic signed [15:0] sine_of(input lfbm_pkg::trig_index_type idx);
      logic [1:0]                        quad;
      logic [lfbm_pkg::QUARTER_BITS-1:0] r;
      logic [lfbm_pkg::QUARTER_BITS-1:0] r_mirror;
      lfbm_pkg::qval_type                v;
      quad     = idx[lfbm_pkg::TRIG_TABLE_BITS-1 -: 2];
      r        = idx[lfbm_pkg::QUARTER_BITS-1:0];
      r_mirror = (~r) + 1'b1;
      if (quad[0]) begin
         v = (r == '0) ? lfbm_pkg::QTOP : lfbm_pkg::QTAB[r_mirror];
      end else begin
         v = lfbm_pkg::QTAB[r];
      end
      return quad[1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
   endfunction

   lfbm_pkg::trig_index_type cos_index;
   logic signed [15:0]       sin_v;
   logic signed [15:0]       cos_v;
   logic signed [32:0]       prod_x;
   logic signed [32:0]       prod_y;
   logic signed [18:0]       x_pos;
   logic signed [18:0]       y_pos;
   logic signed [18:0]       hw;
   logic signed [18:0]       front;
   logic signed [18:0]       back;
   logic [16:0]              masked_sum;

   assign cos_index = trig_index + lfbm_pkg::trig_index_type'(lfbm_pkg::TABLE_QUARTER);
   assign sin_v     = sine_of(trig_index);
   assign cos_v     = sine_of(cos_index);

   assign prod_x = $signed({1'b0, range_mm}) * sin_v;
   assign prod_y = $signed({1'b0, range_mm}) * cos_v;

   // Dropping the low 15 bits of a signed product rounds toward minus infinity.
   assign x_pos = 19'($signed(prod_x[32:15]));
   assign y_pos = -(19'($signed(prod_y[32:15])));

   assign hw    = $signed({4'b0, cfg.half_width_mm});
   assign front = 19'(cfg.front_limit_mm);
   assign back  = 19'(cfg.back_limit_mm);

   assign masked = (x_pos > -hw) && (x_pos < hw) && (y_pos < front) && (y_pos > back);

   assign masked_sum   = {1'b0, cfg.range_max_mm} + 17'd1000;
   assign out_range_mm = !masked ? range_mm :
                         (masked_sum[16] ? 16'hFFFF : masked_sum[15:0]);

endmodule

// File: design/lidar_footprint_box_mask.sv
//------------------------------------------------------------------------------
// Lidar footprint box mask
// Replaces range samples that fall inside the robot footprint box.
//------------------------------------------------------------------------------
// Requests arrive on req_valid / req_stall / req_data, one range sample each,
// with scan_end set on the last sample of a scan. Results leave on
// rsp_valid / rsp_stall / rsp_data. A request is taken when valid is high and
// stall is low.
// The block runs at one request per clock unless req_stall is high. A request is
// captured in an input register together with its beam angle, then projected
// and tested against the box combinationally; its result then moves into the
// result register, from which it is taken.
// The beam angle starts at half a turn, drops by phase_step per sample and
// returns to half a turn after each scan end. Requests within the first
// skip_scans scans advance the angle but produce no result.
// When rsp_stall holds the result register full, the input register still
// takes one more request; further requests are stalled until space frees.
// Synchronous reset loads all register defaults and the skip count, and
// empties both stages. Registers are written through csr_* with no wait.
//------------------------------------------------------------------------------
`include "lidar_footprint_box_mask_defines.svh"

module lidar_footprint_box_mask (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  lfbm_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output lfbm_pkg::rsp_type                   rsp_data,
   input  logic                                csr_wr_en,
   input  logic [lfbm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lfbm_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   lfbm_pkg::cfg_type        cfg_ff;
   lfbm_pkg::cfg_type        cfg_in;
   logic [lfbm_pkg::SKIP_W-1:0] skip_cfg_ff;
   logic [lfbm_pkg::SKIP_W-1:0] skip_cfg_in;
   logic [lfbm_pkg::SKIP_W-1:0] skip_cnt_ff;
   logic [lfbm_pkg::SKIP_W-1:0] skip_cnt_in;
   lfbm_pkg::phase_type      phase_ff;
   lfbm_pkg::phase_type      phase_in;

   logic                     s1_valid_ff;
   logic                     s1_valid_in;
   lfbm_pkg::req_type        s1_req_ff;
   lfbm_pkg::trig_index_type s1_index_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   lfbm_pkg::rsp_type        rsp_data_ff;

   logic                     accept;
   logic                     s1_move;
   logic                     chk_masked;
   logic [15:0]              chk_range;
   lfbm_pkg::csr_index_type  csr_code;

   assign accept    = req_valid && !req_stall;
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && rsp_valid_ff && rsp_stall;
   assign csr_code  = lfbm_pkg::csr_index_type'(csr_index);

   // Configuration writes.
   always_comb begin
      cfg_in      = cfg_ff;
      skip_cfg_in = skip_cfg_ff;
      if (csr_wr_en) begin
         case (csr_code)
            lfbm_pkg::CSR_HALF_WIDTH:  cfg_in.half_width_mm  = csr_wr_data[14:0];
            lfbm_pkg::CSR_FRONT_LIMIT: cfg_in.front_limit_mm = $signed(csr_wr_data[15:0]);
            lfbm_pkg::CSR_BACK_LIMIT:  cfg_in.back_limit_mm  = $signed(csr_wr_data[15:0]);
            lfbm_pkg::CSR_RANGE_MAX:   cfg_in.range_max_mm   = csr_wr_data[15:0];
            lfbm_pkg::CSR_PHASE_STEP:  cfg_in.phase_step     = csr_wr_data[23:0];
            lfbm_pkg::CSR_SKIP_SCANS:  skip_cfg_in = csr_wr_data[lfbm_pkg::SKIP_W-1:0];
            default: ;
         endcase
      end
   end

   // Beam angle moves with each accepted request, skip count at each scan end.
   always_comb begin
      phase_in    = phase_ff;
      skip_cnt_in = skip_cnt_ff;
      if (accept) begin
         if (req_data.scan_end) begin
            phase_in = lfbm_pkg::PHASE_HALF;
            if (skip_cnt_ff != '0) begin
               skip_cnt_in = skip_cnt_ff - 1'b1;
            end
         end else begin
            phase_in = phase_ff - lfbm_pkg::phase_type'(cfg_ff.phase_step);
         end
      end
      if (csr_wr_en && (csr_code == lfbm_pkg::CSR_SKIP_SCANS)) begin
         skip_cnt_in = csr_wr_data[lfbm_pkg::SKIP_W-1:0];
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = (skip_cnt_ff == '0);
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_width_mm  <= 15'd290;
         cfg_ff.front_limit_mm <= 16'sd240;
         cfg_ff.back_limit_mm  <= -16'sd200;
         cfg_ff.range_max_mm   <= 16'd12000;
         cfg_ff.phase_step     <= 24'd19508;
         skip_cfg_ff           <= 8'd20;
         skip_cnt_ff           <= 8'd20;
         phase_ff              <= lfbm_pkg::PHASE_HALF;
         s1_valid_ff           <= 1'b0;
         rsp_valid_ff          <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         skip_cfg_ff  <= skip_cfg_in;
         skip_cnt_ff  <= skip_cnt_in;
         phase_ff     <= phase_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff   <= req_data;
         s1_index_ff <= phase_ff[lfbm_pkg::PHASE_BITS-1 -: lfbm_pkg::TRIG_TABLE_BITS];
      end
      if (s1_move) begin
         rsp_data_ff.out_range_mm  <= chk_range;
         rsp_data_ff.out_intensity <= s1_req_ff.intensity;
         rsp_data_ff.out_scan_end  <= s1_req_ff.scan_end;
         rsp_data_ff.masked        <= chk_masked;
      end
   end

   lfbm_point_check u_check (
      .cfg          (cfg_ff),
      .trig_index   (s1_index_ff),
      .range_mm     (s1_req_ff.range_mm),
      .masked       (chk_masked),
      .out_range_mm (chk_range)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A masked result always carries the saturated replacement range.
   `LFBM_ASSERT_SAME(a_masked_range, clock, reset, rsp_valid && rsp_data.masked, rsp_data.out_range_mm == ((cfg_ff.range_max_mm > 16'd64535) ? 16'hFFFF : (cfg_ff.range_max_mm + 16'd1000)))
   // The beam angle returns to half a turn after a scan end.
   `LFBM_ASSERT_NEXT(a_phase_restart, clock, reset, accept && req_data.scan_end, phase_ff == lfbm_pkg::PHASE_HALF)
   // Requests taken while scans are being skipped never reach the result stage.
   `LFBM_ASSERT_NEXT(a_skip_drops, clock, reset, accept && (skip_cnt_ff != '0), !s1_valid_ff)

endmodule

// File: dv/tb_top.sv
//------------------------------------------------------------------------------
// Footprint box mask testbench
// Streams range samples through the block and compares every result with a
// sample-by-sample prediction. The prediction keeps its own beam angle, skip
// count and settings. Directed samples cover the reset settings and the
// extreme settings. Random scans follow, under changing idle patterns.
//------------------------------------------------------------------------------
module tb_top;

   localparam int SINE_BITS     = 10;
   localparam int ANGLE_BITS    = 24;
   localparam int SINE_SIZE     = 1 << SINE_BITS;
   localparam int SINE_QUARTER  = SINE_SIZE / 4;
   localparam logic [ANGLE_BITS-1:0] HALF_TURN = 24'h800000;
   localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

   // Indexes past the last register; writes to them must change nothing.
   localparam logic [lfbm_pkg::CSR_INDEX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [lfbm_pkg::CSR_INDEX_W-1:0] CSR_SPARE_7 = 3'd7;

   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_SAMPLES  = 16;
   localparam int SKIP_ALL_PHASE = 5;
   localparam int HOLD_CYCLES    = 80;
   localparam int HOLD_EVERY     = 100;
   localparam int SETTLE_CYCLES  = 8;
   localparam int DRAIN_LIMIT    = 50000;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   lfbm_pkg::req_type                req_data = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   lfbm_pkg::rsp_type                rsp_data;
   logic                             csr_wr_en = 1'b0;
   logic [lfbm_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [lfbm_pkg::CSR_DATA_W-1:0]  csr_wr_data = '0;

   // Predicted block state and settings, starting from their reset values.
   int                     sine_q15 [SINE_SIZE];
   int                     half_width = 290;
   int                     front_limit = 240;
   int                     back_limit = -200;
   int                     sensor_max_mm = 12000;
   logic [ANGLE_BITS-1:0]  angle_step = 24'd19508;
   logic [ANGLE_BITS-1:0]  beam_angle = HALF_TURN;
   logic [7:0]             scans_left = 8'd20;

   lfbm_pkg::req_type      samples_to_send [$];
   lfbm_pkg::rsp_type      filtered_samples [$];
   int unsigned            mismatches = 0;
   int unsigned            send_idle_pct = 0;
   int unsigned            recv_idle_pct = 0;
   int unsigned            results_seen = 0;
   int                     hold_left = 0;
   int                     scan_len;

   wire                    rsp_fire = !reset && rsp_valid && !rsp_stall;

   lidar_footprint_box_mask u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // First-quadrant sine in Q15: Taylor series summed in Q30 with truncation.
   function automatic int taylor_quarter_sine(input int unsigned k);
      longint unsigned ang;
      longint unsigned ang_sq;
      longint unsigned term;
      longint          acc;
      longint          q;
      ang    = (QUARTER_TURN_Q30 * k) / SINE_QUARTER;
      ang_sq = (ang * ang) >> 30;
      term   = ang;
      acc    = longint'(ang);
      for (int n = 1; n <= 8; n++) begin
         term = (term * ang_sq) >> 30;
         term = term / longint'(2 * n * (2 * n + 1));
         if (n % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      q = (acc + 16384) >>> 15;
      if (q > 32767) begin
         q = 32767;
      end
      return int'(q);
   endfunction

   task automatic build_sine_q15();
      int quad;
      int rem;
      int v;
      for (int k = 0; k < SINE_SIZE; k++) begin
         quad = k / SINE_QUARTER;
         rem  = k % SINE_QUARTER;
         if (quad % 2 == 1) begin
            v = taylor_quarter_sine(SINE_QUARTER - rem);
         end else begin
            v = taylor_quarter_sine(rem);
         end
         sine_q15[k] = (quad >= 2) ? -v : v;
      end
   endtask

   // Projects one accepted sample and records any result it should give.
   task automatic filter_sample(input lfbm_pkg::req_type s);
      logic [SINE_BITS-1:0] sin_idx;
      logic [SINE_BITS-1:0] cos_idx;
      longint               x;
      longint               y;
      bit                   in_box;
      int                   out_range;
      lfbm_pkg::rsp_type    r;
      sin_idx = beam_angle[ANGLE_BITS-1 -: SINE_BITS];
      cos_idx = sin_idx + SINE_BITS'(SINE_QUARTER);
      x = (longint'(s.range_mm) * sine_q15[sin_idx]) >>> 15;
      y = -((longint'(s.range_mm) * sine_q15[cos_idx]) >>> 15);
      in_box = (x > -longint'(half_width)) && (x < half_width) &&
               (y < front_limit) && (y > back_limit);
      if (scans_left == 0) begin
         if (in_box) begin
            out_range = sensor_max_mm + 1000;
            if (out_range > 65535) begin
               out_range = 65535;
            end
         end else begin
            out_range = int'(s.range_mm);
         end
         r.out_range_mm  = 16'(out_range);
         r.out_intensity = s.intensity;
         r.out_scan_end  = s.scan_end;
         r.masked        = in_box;
         filtered_samples.push_back(r);
      end
      if (s.scan_end) begin
         if (scans_left != 0) begin
            scans_left = scans_left - 8'd1;
         end
         beam_angle = HALF_TURN;
      end else begin
         beam_angle = beam_angle - angle_step;
      end
   endtask

   task automatic match_output(input lfbm_pkg::rsp_type got);
      lfbm_pkg::rsp_type want;
      if (filtered_samples.size() == 0) begin
         $error("unexpected result: out_range_mm %0d", got.out_range_mm);
         mismatches++;
      end else begin
         want = filtered_samples.pop_front();
         if (got.out_range_mm !== want.out_range_mm) begin
            $error("out_range_mm: expected %0d, got %0d", want.out_range_mm,
                   got.out_range_mm);
            mismatches++;
         end
         if (got.out_intensity !== want.out_intensity) begin
            $error("out_intensity: expected %0d, got %0d", want.out_intensity,
                   got.out_intensity);
            mismatches++;
         end
         if (got.out_scan_end !== want.out_scan_end) begin
            $error("out_scan_end: expected %0d, got %0d", want.out_scan_end,
                   got.out_scan_end);
            mismatches++;
         end
         if (got.masked !== want.masked) begin
            $error("masked: expected %0d, got %0d", want.masked, got.masked);
            mismatches++;
         end
      end
   endtask

   // Request driver: a new request is offered only when the last one was taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            filter_sample(req_data);
         end
         if (!req_valid || !req_stall) begin
            if (samples_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_data  <= samples_to_send.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor. Every so often it holds off for a long stretch so the
   // block fills up and has to stall its input.
   always @(posedge clock) begin
      if (rsp_fire) begin
         match_output(rsp_data);
         results_seen <= results_seen + 1;
      end
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (rsp_fire && results_seen % HOLD_EVERY == HOLD_EVERY - 1) begin
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   task automatic queue_sample(input logic [15:0] range_mm, input logic [15:0] intensity,
                               input logic scan_end);
      lfbm_pkg::req_type s;
      s.range_mm  = range_mm;
      s.intensity = intensity;
      s.scan_end  = scan_end;
      samples_to_send.push_back(s);
   endtask

   // Mostly short ranges so that points land in the box, with some wide
   // values and the two extremes.
   function automatic logic [15:0] pick_range();
      int unsigned p;
      p = $urandom_range(0, 99);
      if (p < 60) begin
         return 16'($urandom_range(0, 2000));
      end else if (p < 90) begin
         return 16'($urandom);
      end else if (p < 95) begin
         return 16'h0000;
      end else begin
         return 16'hFFFF;
      end
   endfunction

   // Scans mostly of the expected length, some much shorter or longer.
   task automatic queue_scans(input int n_samples, input int nominal_len);
      int sent;
      int len;
      sent = 0;
      while (sent < n_samples) begin
         if ($urandom_range(0, 99) < 80) begin
            len = nominal_len + int'($urandom_range(0, 2)) - 1;
         end else begin
            len = int'($urandom_range(1, 3 * nominal_len));
         end
         for (int i = 0; i < len; i++) begin
            queue_sample(pick_range(), 16'($urandom), i == len - 1);
         end
         sent = sent + len;
      end
   endtask

   // Unused upper data bits are filled with noise; the register keeps only
   // its own width.
   task automatic write_reg(input logic [lfbm_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [lfbm_pkg::CSR_DATA_W-1:0] value, input int width);
      logic [lfbm_pkg::CSR_DATA_W-1:0] mask;
      logic [lfbm_pkg::CSR_DATA_W-1:0] d;
      mask = lfbm_pkg::CSR_DATA_W'((32'd1 << width) - 1);
      d    = (lfbm_pkg::CSR_DATA_W'($urandom) & ~mask) | (value & mask);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= d;
      case (idx)
         lfbm_pkg::CSR_HALF_WIDTH:  half_width    = int'(d[14:0]);
         lfbm_pkg::CSR_FRONT_LIMIT: front_limit   = int'($signed(d[15:0]));
         lfbm_pkg::CSR_BACK_LIMIT:  back_limit    = int'($signed(d[15:0]));
         lfbm_pkg::CSR_RANGE_MAX:   sensor_max_mm = int'(d[15:0]);
         lfbm_pkg::CSR_PHASE_STEP:  angle_step    = d;
         lfbm_pkg::CSR_SKIP_SCANS:  scans_left    = d[7:0];
         default: ;
      endcase
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // Waits until every request is taken and every result has come back,
   // then lets the pipeline settle in case skipped samples are still inside.
   task automatic drain();
      int waited;
      waited = 0;
      while ((samples_to_send.size() != 0 || req_valid || filtered_samples.size() != 0)
             && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (filtered_samples.size() != 0) begin
         $error("%0d results never arrived", filtered_samples.size());
         mismatches++;
         filtered_samples.delete();
      end
   endtask

   task automatic write_all(input int hw, input int front, input int back, input int rmax,
                            input int step, input int skip);
      write_reg(lfbm_pkg::CSR_HALF_WIDTH, lfbm_pkg::CSR_DATA_W'(hw), 15);
      write_reg(lfbm_pkg::CSR_FRONT_LIMIT, lfbm_pkg::CSR_DATA_W'(front), 16);
      write_reg(lfbm_pkg::CSR_BACK_LIMIT, lfbm_pkg::CSR_DATA_W'(back), 16);
      write_reg(lfbm_pkg::CSR_RANGE_MAX, lfbm_pkg::CSR_DATA_W'(rmax), 16);
      write_reg(lfbm_pkg::CSR_PHASE_STEP, lfbm_pkg::CSR_DATA_W'(step), 24);
      write_reg(lfbm_pkg::CSR_SKIP_SCANS, lfbm_pkg::CSR_DATA_W'(skip), 8);
   endtask

   task automatic random_settings(input int phase, output int nominal_len);
      int hw;
      int front;
      int back;
      int rmax;
      int step;
      int skip;
      nominal_len = int'($urandom_range(4, 32));
      hw    = ($urandom_range(0, 99) < 70) ? int'($urandom_range(0, 1500)) : int'($urandom);
      front = ($urandom_range(0, 99) < 70) ? int'($urandom_range(0, 3000)) - 500
                                           : int'($urandom);
      back  = ($urandom_range(0, 99) < 70) ? 500 - int'($urandom_range(0, 3000))
                                           : int'($urandom);
      case ($urandom_range(0, 3))
         0:       rmax = int'($urandom_range(64000, 65535));
         1:       rmax = int'($urandom_range(0, 20000));
         default: rmax = int'($urandom_range(0, 65535));
      endcase
      if ($urandom_range(0, 99) < 80) begin
         step = (1 << ANGLE_BITS) / nominal_len;
      end else if ($urandom_range(0, 1) == 0) begin
         step = int'($urandom_range(0, (1 << ANGLE_BITS) - 1));
      end else begin
         step = int'($urandom_range(0, 3));
      end
      if (phase == SKIP_ALL_PHASE) begin
         skip = 255;
      end else begin
         skip = ($urandom_range(0, 99) < 75) ? 0 : int'($urandom_range(1, 2));
      end
      write_all(hw, front, back, rmax, step, skip);
      if ($urandom_range(0, 3) == 0) begin
         write_reg($urandom_range(0, 1) ? CSR_SPARE_6 : CSR_SPARE_7,
                   lfbm_pkg::CSR_DATA_W'($urandom), 24);
      end
      end_writes();
   endtask

   initial begin
      build_sine_q15();
      send_idle_pct <= 24;
      recv_idle_pct <= 85;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: twenty whole scans are dropped, then the first beam
      // points straight ahead, so short ranges fall in the box.
      repeat (20) queue_sample(16'($urandom), 16'($urandom), 1'b1);
      queue_sample(16'd0, 16'h0000, 1'b0);
      queue_sample(16'd100, 16'hFFFF, 1'b0);
      queue_sample(16'd239, 16'h5A5A, 1'b0);
      queue_sample(16'd240, 16'hA5A5, 1'b0);
      queue_sample(16'hFFFF, 16'h0001, 1'b1);
      drain();

      // Narrowest box and a range maximum of zero. The largest step moves the
      // angle up by one unit per sample, so it wraps the other way.
      write_all(1, 32767, -32768, 0, (1 << ANGLE_BITS) - 1, 0);
      write_reg(CSR_SPARE_6, lfbm_pkg::CSR_DATA_W'($urandom), 24);
      write_reg(CSR_SPARE_7, lfbm_pkg::CSR_DATA_W'($urandom), 24);
      end_writes();
      queue_sample(16'd0, 16'hFFFF, 1'b0);
      queue_sample(16'd5, 16'h0000, 1'b0);
      queue_sample(16'd32766, 16'h1234, 1'b0);
      queue_sample(16'hFFFF, 16'hFFFF, 1'b0);
      queue_sample(16'd2, 16'h8000, 1'b1);
      drain();

      // Widest box, saturated masked range, and a step of zero.
      write_all(32767, 32767, -32768, 65535, 0, 0);
      end_writes();
      queue_sample(16'd0, 16'h0F0F, 1'b0);
      queue_sample(16'd32766, 16'hF0F0, 1'b0);
      queue_sample(16'd32767, 16'h7FFF, 1'b0);
      queue_sample(16'd32768, 16'h0000, 1'b0);
      queue_sample(16'hFFFF, 16'hFFFF, 1'b1);
      drain();

      // Empty box, two skipped scans, and the smallest nonzero step.
      write_all(32767, -32768, 32767, 64536, 1, 2);
      end_writes();
      queue_sample(16'd10, 16'h1111, 1'b1);
      queue_sample(16'd20, 16'h2222, 1'b1);
      queue_sample(16'd0, 16'h3333, 1'b0);
      queue_sample(16'd50, 16'h4444, 1'b0);
      queue_sample(16'hFFFF, 16'h5555, 1'b1);
      drain();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == RANDOM_PHASES / 3) begin
            send_idle_pct <= 85;
            recv_idle_pct <= 24;
         end else if (phase == 2 * RANDOM_PHASES / 3) begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
         end
         random_settings(phase, scan_len);
         if (phase == SKIP_ALL_PHASE) begin
            repeat (255) queue_sample(pick_range(), 16'($urandom), 1'b1);
         end
         queue_scans(PHASE_SAMPLES, scan_len);
         drain();
      end

      if (mismatches == 0) begin
         $display("PASS lidar_footprint_box_mask");
      end else begin
         $display("FAIL lidar_footprint_box_mask");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("FAIL lidar_footprint_box_mask");
      $finish;
   end

endmodule
